### rtl/mrc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
package mrc_pkg;

	localparam int MAX_FRAME_DEFAULT = 256;

	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 16;
	localparam int MINLEN_W = 9;
	localparam int PLEN_W  = 8;
	localparam int ADDR_W  = 4;
	localparam int APB_W   = 32;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CRC_W-1:0]    CRC_START    = 16'hFFFF;
	localparam logic [CRC_W-1:0]    CRC_POLY     = 16'hA001;
	localparam logic [BYTE_W-1:0]   FN_CODE_MASK = 8'h7F;

	localparam logic [BYTE_W-1:0]   SLAVE_RESET  = 8'd0;
	localparam logic [BYTE_W-1:0]   FUNC_RESET   = 8'd0;
	localparam logic [MINLEN_W-1:0] MINLEN_RESET = 9'd4;

	// Item kinds carried on tlast.
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_SLAVE  = 2'd0;
	localparam logic [1:0] REG_FUNC   = 2'd1;
	localparam logic [1:0] REG_MINLEN = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_DATA   = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_CRC_ERR   = 3'd3,
		ST_MISMATCH  = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   slave;
		logic [BYTE_W-1:0]   func;
		logic [MINLEN_W-1:0] min_len;
	} cfg_t;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [PLEN_W-1:0] plen;
		logic              exc;
	} result_t;

	// One received byte through the reflected Modbus CRC, eight shift steps.
	function automatic logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/mrc_in_stage.sv
// Input register stage: captures one stream item and holds it while an end of frame must wait.
module mrc_in_stage
	import mrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              s_tlast,
	input  logic              out_busy,
	output item_t             item_s1,
	output logic              fire_s1
);

	logic valid_s1;

	// Data bytes never wait; an end of frame waits only for a free result register.
	assign fire_s1  = valid_s1 && !(item_s1.op == OP_EOF && out_busy);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op   <= s_tlast;
			item_s1.data <= s_tdata;
		end
	end

endmodule

### rtl/mrc_frame.sv
// Frame state, CRC accumulation and end-of-frame status decision.
module mrc_frame
	import mrc_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item_s1,
	input  logic    fire_s1,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic [CNT_W-1:0]  count_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] older_q;
	logic [BYTE_W-1:0] newer_q;
	logic [BYTE_W-1:0] slave_q;
	logic [BYTE_W-1:0] func_q;

	logic [MINLEN_W-1:0] count_ext;
	logic [CRC_W-1:0]    rx_crc;

	assign count_ext = MINLEN_W'(count_q);
	assign rx_crc    = {newer_q, older_q};

	always_comb begin
		res.valid  = fire_s1 && (item_s1.op == OP_EOF);
		res.status = ST_OK;
		res.plen   = '0;
		res.exc    = func_q[BYTE_W-1];
		if (count_q == '0) begin
			res.status = ST_NO_DATA;
		end else if (count_q < CNT_W'(2) || count_ext < cfg.min_len) begin
			res.status = ST_TOO_SHORT;
		end else if (crc_q != rx_crc) begin
			res.status = ST_CRC_ERR;
		end else if (cfg.slave != slave_q || cfg.func != (func_q & FN_CODE_MASK)) begin
			res.status = ST_MISMATCH;
		end else begin
			res.plen = PLEN_W'(count_q - CNT_W'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_START;
			older_q <= '0;
			newer_q <= '0;
			slave_q <= '0;
			func_q  <= '0;
		end else if (fire_s1) begin
			if (item_s1.op == OP_EOF) begin
				count_q <= '0;
				crc_q   <= CRC_START;
				older_q <= '0;
				newer_q <= '0;
				slave_q <= '0;
				func_q  <= '0;
			end else if (count_q < CNT_W'(MAX_FRAME)) begin
				if (count_q == '0) begin
					slave_q <= item_s1.data;
				end else if (count_q == CNT_W'(1)) begin
					func_q <= item_s1.data;
				end
				// The two newest bytes are the candidate CRC; only older ones enter it.
				if (count_q >= CNT_W'(2)) begin
					crc_q <= crc_step(crc_q, older_q);
				end
				older_q <= newer_q;
				newer_q <= item_s1.data;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

### rtl/mrc_out_stage.sv
// Result register on the master side of the stream.
module mrc_out_stage
	import mrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  result_t                res,
	output logic                   out_busy,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic                   valid_q;
	logic [OUT_TDATA_W-1:0] data_q;

	assign out_busy = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			data_q <= {4'b0000, res.exc, res.plen, res.status};
		end
	end

endmodule

### rtl/modbus_rtu_response_checker_top.sv
// Top level of the Modbus RTU response checker: APB registers and the stream stages.
//
// Received bytes enter on the slave stream, one item per byte; an item with
// s_tlast high is the end-of-frame marker and its data byte is ignored. Each
// end of frame yields one result item on the master stream; data bytes yield
// none. The CRC-16 (poly 0xA001, start 0xFFFF) of all bytes but the last two
// is compared with those two bytes, low byte first.
// Throughput is one item per cycle unless an end of frame waits; the eight-step
// CRC byte update works on bytes already held in the frame state. An end of
// frame is captured in the input register, evaluated from there, and its
// result is registered in the result register that drives m_tvalid.
// When the receiver stalls, data bytes still flow; an end of frame waits in the
// input register while the previous result is untaken, and s_tready drops only
// then. Reset clears both streams, the frame state and the registers
// (expected slave 0, expected function 0, minimum length 4). The APB port
// is always ready; write registers only while no frame is in progress.
module modbus_rtu_response_checker_top
	import mrc_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// s_tdata: data_byte[7:0]; s_tlast: operation (end of frame)
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,
	input  logic                   s_tlast,
	// m_tdata: status[2:0], payload_length[10:3], is_exception[11], zeros[15:12]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_W-1:0]       pwdata,
	output logic [APB_W-1:0]       prdata,
	output logic                   pready
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    fire_s1;
	logic    out_busy;
	result_t res;

	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave   <= SLAVE_RESET;
			cfg_q.func    <= FUNC_RESET;
			cfg_q.min_len <= MINLEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SLAVE:  cfg_q.slave   <= pwdata[BYTE_W-1:0];
				REG_FUNC:   cfg_q.func    <= pwdata[BYTE_W-1:0];
				REG_MINLEN: cfg_q.min_len <= pwdata[MINLEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SLAVE:  prdata = APB_W'(cfg_q.slave);
			REG_FUNC:   prdata = APB_W'(cfg_q.func);
			REG_MINLEN: prdata = APB_W'(cfg_q.min_len);
			default:    prdata = '0;
		endcase
	end

	mrc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_busy (out_busy),
		.item_s1  (item_s1),
		.fire_s1  (fire_s1)
	);

	mrc_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.fire_s1 (fire_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	mrc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_busy (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
